// ----- design/dcdc_fault_supervisor_top_defines.svh -----
// assertion macros shared by the supervisor modules
// the enclosing module must provide clk and rst_n
`ifndef DCDC_FAULT_SUPERVISOR_TOP_DEFINES_SVH
`define DCDC_FAULT_SUPERVISOR_TOP_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define DCDCFS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define DCDCFS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DCDCFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/dcdcfs_pkg.sv -----
// shared types, codes and constants of the dc-dc fault supervisor
// no dependencies
`timescale 1ns / 1ps

package dcdcfs_pkg;

    localparam int RECURRENCE_LIMIT = 5;
    localparam int PERIOD_MIN       = 100;
    localparam int PERIOD_MAX       = 1000;
    localparam int NUM_COUNTERS     = 5;

    localparam logic [2:0]  REC_LIMIT    = 3'(RECURRENCE_LIMIT);
    localparam logic [15:0] PERIOD_MIN_W = 16'(PERIOD_MIN);
    localparam logic [15:0] PERIOD_MAX_W = 16'(PERIOD_MAX);

    // operation codes
    localparam logic [3:0] OP_TICK       = 4'd0;
    localparam logic [3:0] OP_TEMPS      = 4'd1;
    localparam logic [3:0] OP_START      = 4'd2;
    localparam logic [3:0] OP_STOP       = 4'd3;
    localparam logic [3:0] OP_OPENLOOP   = 4'd4;
    localparam logic [3:0] OP_OL_PRIMARY = 4'd5;
    localparam logic [3:0] OP_OL_SR      = 4'd6;
    localparam logic [3:0] OP_OL_DUMMY   = 4'd7;
    localparam logic [3:0] OP_PERIOD     = 4'd8;
    localparam logic [3:0] OP_CNT_RESET  = 4'd9;

    // converter sequence states
    localparam logic [2:0] MODE_SHUTDOWN    = 3'd0;
    localparam logic [2:0] MODE_OPENLOOP    = 3'd1;
    localparam logic [2:0] MODE_WAITCRIT    = 3'd2;
    localparam logic [2:0] MODE_WAITPFC     = 3'd3;
    localparam logic [2:0] MODE_WAITNONCRIT = 3'd4;
    localparam logic [2:0] MODE_SOFTSTART   = 3'd5;
    localparam logic [2:0] MODE_NORMAL      = 3'd6;
    localparam logic [2:0] MODE_LIGHTLOAD   = 3'd7;

    // drive bits
    localparam logic [2:0] DRV_PRI   = 3'b001;
    localparam logic [2:0] DRV_SR    = 3'b010;
    localparam logic [2:0] DRV_DUMMY = 3'b100;

    // fault flag / event counter positions
    localparam int FLAG_HWOC = 0;
    localparam int FLAG_SWOC = 1;
    localparam int FLAG_OT1  = 2;
    localparam int FLAG_OT2  = 3;
    localparam int FLAG_OV   = 4;

    // configuration register indexes
    localparam logic [2:0] REG_OVP_TRIP    = 3'd0;
    localparam logic [2:0] REG_OVP_RELEASE = 3'd1;
    localparam logic [2:0] REG_OCP_TRIP    = 3'd2;
    localparam logic [2:0] REG_OCP_RELEASE = 3'd3;
    localparam logic [2:0] REG_LL_ENTER    = 3'd4;
    localparam logic [2:0] REG_LL_EXIT     = 3'd5;
    localparam logic [2:0] REG_OTP_TRIP    = 3'd6;
    localparam logic [2:0] REG_OTP_RELEASE = 3'd7;

    localparam logic [11:0]        RST_OVP_TRIP    = 12'd4095;
    localparam logic [11:0]        RST_OVP_RELEASE = 12'd4000;
    localparam logic [11:0]        RST_OCP_TRIP    = 12'd4095;
    localparam logic [11:0]        RST_OCP_RELEASE = 12'd4000;
    localparam logic [11:0]        RST_LL_ENTER    = 12'd200;
    localparam logic [11:0]        RST_LL_EXIT     = 12'd340;
    localparam logic signed [15:0] RST_OTP_TRIP    = 16'sd10000;
    localparam logic signed [15:0] RST_OTP_RELEASE = 16'sd9000;

    typedef struct packed {
        logic [11:0]        ovp_trip_raw;
        logic [11:0]        ovp_release_raw;
        logic [11:0]        ocp_trip_raw;
        logic [11:0]        ocp_release_raw;
        logic [11:0]        light_load_enter_raw;
        logic [11:0]        light_load_exit_raw;
        logic signed [15:0] otp_trip_x100;
        logic signed [15:0] otp_release_x100;
    } cfg_t;

    typedef struct packed {
        logic [3:0]         op;
        logic               trip_flag;
        logic [11:0]        output_current_raw;
        logic [11:0]        output_voltage_raw;
        logic               pfc_fault_pin;
        logic               interlock_pin;
        logic signed [15:0] heatsink_1_sample;
        logic signed [15:0] heatsink_2_sample;
        logic               enable_arg;
        logic [15:0]        period_arg;
        logic [2:0]         counter_select;
    } item_t;

    typedef struct packed {
        logic noncritical;
        logic critical;
    } fault_sum_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [2:0]  drive;
        logic [15:0] period;
        logic        accepted;
    } seq_status_t;

    typedef struct packed {
        logic [2:0]         converter_mode;
        logic               primary_pwm_on;
        logic               sync_rect_on;
        logic               dummy_load_on;
        logic               noncritical_active;
        logic               critical_active;
        logic               command_accepted;
        logic [15:0]        primary_period;
        logic signed [15:0] heatsink_1_temp;
        logic signed [15:0] heatsink_2_temp;
        logic [15:0]        event_count;
    } result_t;

    // first-order filter, alpha 1/16; floor division is an arithmetic shift
    function automatic logic signed [15:0] filter_step(
        input logic signed [15:0] f,
        input logic signed [15:0] s
    );
        logic signed [16:0] diff;
        logic signed [16:0] step;
        logic signed [16:0] res;
        diff = {f[15], f} - {s[15], s};
        step = diff >>> 4;
        res  = {f[15], f} - step;
        return res[15:0];
    endfunction

endpackage

// ----- design/dcdcfs_cfg.sv -----
// threshold register file written through the configuration channel
// depends on dcdcfs_pkg
`timescale 1ns / 1ps

module dcdcfs_cfg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [2:0]        wr_index,
    input  logic [15:0]       wr_data,
    output dcdcfs_pkg::cfg_t  cfg
);
    import dcdcfs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_OVP_TRIP:    cfg_next.ovp_trip_raw         = wr_data[11:0];
                REG_OVP_RELEASE: cfg_next.ovp_release_raw      = wr_data[11:0];
                REG_OCP_TRIP:    cfg_next.ocp_trip_raw         = wr_data[11:0];
                REG_OCP_RELEASE: cfg_next.ocp_release_raw      = wr_data[11:0];
                REG_LL_ENTER:    cfg_next.light_load_enter_raw = wr_data[11:0];
                REG_LL_EXIT:     cfg_next.light_load_exit_raw  = wr_data[11:0];
                REG_OTP_TRIP:    cfg_next.otp_trip_x100        = wr_data;
                REG_OTP_RELEASE: cfg_next.otp_release_x100     = wr_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ovp_trip_raw         <= RST_OVP_TRIP;
            cfg_reg.ovp_release_raw      <= RST_OVP_RELEASE;
            cfg_reg.ocp_trip_raw         <= RST_OCP_TRIP;
            cfg_reg.ocp_release_raw      <= RST_OCP_RELEASE;
            cfg_reg.light_load_enter_raw <= RST_LL_ENTER;
            cfg_reg.light_load_exit_raw  <= RST_LL_EXIT;
            cfg_reg.otp_trip_x100        <= RST_OTP_TRIP;
            cfg_reg.otp_release_x100     <= RST_OTP_RELEASE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/dcdcfs_faults.sv -----
// fault flags, trip recurrence, event counters and temperature filters
// depends on dcdcfs_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "dcdc_fault_supervisor_top_defines.svh"

module dcdcfs_faults (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    fire,
    input  dcdcfs_pkg::item_t       item,
    input  dcdcfs_pkg::cfg_t        cfg,
    output dcdcfs_pkg::fault_sum_t  summary_next,
    output logic signed [15:0]      temp1_next,
    output logic signed [15:0]      temp2_next,
    output logic [15:0]             count_sel,
    output logic                    sel_ok
);
    import dcdcfs_pkg::*;

    logic [2:0]         rec_reg;
    logic [2:0]         rec_next;
    logic [4:0]         flags_reg;
    logic [4:0]         flags_next;
    fault_sum_t         summary_reg;
    logic [15:0]        cnt_reg  [NUM_COUNTERS];
    logic [15:0]        cnt_next [NUM_COUNTERS];
    logic signed [15:0] temp1_reg;
    logic signed [15:0] temp2_reg;
    logic [4:0]         above;
    logic [4:0]         below;

    assign sel_ok = (item.counter_select < 3'(NUM_COUNTERS));

    // hysteresis compares; the hardware trip slot is handled separately
    always_comb
    begin
        above = '0;
        below = '0;
        above[FLAG_SWOC] = item.output_current_raw > cfg.ocp_trip_raw;
        below[FLAG_SWOC] = item.output_current_raw < cfg.ocp_release_raw;
        above[FLAG_OT1]  = temp1_reg > cfg.otp_trip_x100;
        below[FLAG_OT1]  = temp1_reg < cfg.otp_release_x100;
        above[FLAG_OT2]  = temp2_reg > cfg.otp_trip_x100;
        below[FLAG_OT2]  = temp2_reg < cfg.otp_release_x100;
        above[FLAG_OV]   = item.output_voltage_raw > cfg.ovp_trip_raw;
        below[FLAG_OV]   = item.output_voltage_raw < cfg.ovp_release_raw;
    end

    always_comb
    begin
        rec_next     = rec_reg;
        flags_next   = flags_reg;
        summary_next = summary_reg;
        temp1_next   = temp1_reg;
        temp2_next   = temp2_reg;
        for (int i = 0; i < NUM_COUNTERS; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end
        if (fire)
        begin
            unique case (item.op)
                OP_TICK:
                begin
                    if (item.trip_flag)
                    begin
                        if (({1'b0, rec_reg} + 4'd1) >= {1'b0, REC_LIMIT})
                        begin
                            rec_next              = REC_LIMIT;
                            cnt_next[FLAG_HWOC]   = cnt_reg[FLAG_HWOC] + 16'd1;
                            flags_next[FLAG_HWOC] = 1'b1;
                        end
                        else
                        begin
                            rec_next = rec_reg + 3'd1;
                        end
                    end
                    else if (rec_reg <= 3'd1)
                    begin
                        rec_next              = 3'd0;
                        flags_next[FLAG_HWOC] = 1'b0;
                    end
                    else
                    begin
                        rec_next = rec_reg - 3'd1;
                    end
                    for (int k = FLAG_SWOC; k < NUM_COUNTERS; k++)
                    begin
                        if (above[k])
                        begin
                            cnt_next[k]   = cnt_reg[k] + 16'd1;
                            flags_next[k] = 1'b1;
                        end
                        else if (below[k])
                        begin
                            flags_next[k] = 1'b0;
                        end
                    end
                    summary_next.noncritical = |flags_next;
                    summary_next.critical    = !item.interlock_pin || item.pfc_fault_pin;
                end
                OP_TEMPS:
                begin
                    temp1_next = filter_step(temp1_reg, item.heatsink_1_sample);
                    temp2_next = filter_step(temp2_reg, item.heatsink_2_sample);
                end
                OP_CNT_RESET:
                begin
                    if (sel_ok)
                    begin
                        cnt_next[item.counter_select] = 16'd0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign count_sel = sel_ok ? cnt_next[item.counter_select] : 16'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg     <= 3'd0;
            flags_reg   <= 5'd0;
            summary_reg <= '0;
            temp1_reg   <= 16'sd0;
            temp2_reg   <= 16'sd0;
            for (int i = 0; i < NUM_COUNTERS; i++)
            begin
                cnt_reg[i] <= 16'd0;
            end
        end
        else
        begin
            rec_reg     <= rec_next;
            flags_reg   <= flags_next;
            summary_reg <= summary_next;
            temp1_reg   <= temp1_next;
            temp2_reg   <= temp2_next;
            for (int i = 0; i < NUM_COUNTERS; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    `DCDCFS_ASSERT(a_rec_bound, rec_reg <= REC_LIMIT, "trip recurrence beyond limit")
    `DCDCFS_ASSERT_IMPL(a_rec_full_flag, rec_reg == REC_LIMIT, flags_reg[FLAG_HWOC], "hwoc flag clear at limit")
    `DCDCFS_ASSERT_IMPL(a_rec_zero_flag, rec_reg == 3'd0, !flags_reg[FLAG_HWOC], "hwoc flag set at zero count")

endmodule

// ----- design/dcdcfs_seq.sv -----
// converter sequencer: run/open-loop commands, overrides and mode steps
// depends on dcdcfs_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "dcdc_fault_supervisor_top_defines.svh"

module dcdcfs_seq (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     fire,
    input  dcdcfs_pkg::item_t        item,
    input  dcdcfs_pkg::cfg_t         cfg,
    input  dcdcfs_pkg::fault_sum_t   faults,
    input  logic                     sel_ok,
    output dcdcfs_pkg::seq_status_t  status
);
    import dcdcfs_pkg::*;

    logic [2:0]  mode_reg;
    logic [2:0]  mode_next;
    logic        run_reg;
    logic        run_next;
    logic        olm_reg;
    logic        olm_next;
    logic [2:0]  olr_reg;
    logic [2:0]  olr_next;
    logic [2:0]  drive_reg;
    logic [2:0]  drive_next;
    logic [15:0] period_reg;
    logic [15:0] period_next;
    logic        acc;
    logic [1:0]  olr_bit;

    assign olr_bit = 2'(item.op - OP_OL_PRIMARY);

    always_comb
    begin
        mode_next   = mode_reg;
        run_next    = run_reg;
        olm_next    = olm_reg;
        olr_next    = olr_reg;
        drive_next  = drive_reg;
        period_next = period_reg;
        acc         = 1'b1;
        if (fire)
        begin
            unique case (item.op) inside
                OP_TICK:
                begin
                    if (!run_reg)
                    begin
                        drive_next  = 3'b000;
                        olm_next    = 1'b0;
                        olr_next    = 3'b000;
                        period_next = PERIOD_MIN_W;
                        mode_next   = MODE_SHUTDOWN;
                    end
                    // fault overrides push the sequence back to a wait state
                    if (faults.critical)
                    begin
                        if (mode_next > MODE_WAITPFC)
                        begin
                            drive_next = 3'b000;
                            mode_next  = MODE_WAITCRIT;
                        end
                    end
                    else if (faults.noncritical)
                    begin
                        if (mode_next > MODE_WAITNONCRIT)
                        begin
                            drive_next = 3'b000;
                            mode_next  = MODE_WAITNONCRIT;
                        end
                    end
                    unique case (mode_next)
                        MODE_SHUTDOWN:
                        begin
                            if (run_reg)
                            begin
                                mode_next = olm_next ? MODE_OPENLOOP : MODE_WAITPFC;
                            end
                        end
                        MODE_OPENLOOP:
                        begin
                            drive_next = olr_next;
                            if (faults.noncritical)
                            begin
                                run_next = 1'b0;
                            end
                        end
                        MODE_WAITCRIT:
                        begin
                            if (!faults.critical)
                            begin
                                mode_next = MODE_WAITPFC;
                            end
                        end
                        MODE_WAITPFC:
                        begin
                            if (!faults.critical)
                            begin
                                mode_next = MODE_WAITNONCRIT;
                            end
                        end
                        MODE_WAITNONCRIT:
                        begin
                            if (!faults.noncritical)
                            begin
                                drive_next = drive_next | DRV_PRI | DRV_SR;
                                mode_next  = MODE_SOFTSTART;
                            end
                        end
                        MODE_SOFTSTART:
                        begin
                            mode_next = MODE_NORMAL;
                        end
                        MODE_NORMAL:
                        begin
                            if (item.output_current_raw < cfg.light_load_enter_raw)
                            begin
                                drive_next = drive_next | DRV_DUMMY;
                                mode_next  = MODE_LIGHTLOAD;
                            end
                        end
                        default:
                        begin
                            // light load
                            if (item.output_current_raw > cfg.light_load_exit_raw)
                            begin
                                drive_next = drive_next & ~DRV_DUMMY;
                                mode_next  = MODE_NORMAL;
                            end
                        end
                    endcase
                end
                OP_TEMPS:
                begin
                    acc = 1'b1;
                end
                OP_START:
                begin
                    run_next = 1'b1;
                end
                OP_STOP:
                begin
                    run_next = 1'b0;
                end
                OP_OPENLOOP:
                begin
                    acc = 1'b0;
                    if (item.enable_arg && (mode_reg == MODE_SHUTDOWN))
                    begin
                        olm_next = 1'b1;
                        run_next = 1'b1;
                        acc      = 1'b1;
                    end
                    else if (!item.enable_arg && (mode_reg == MODE_OPENLOOP))
                    begin
                        olm_next = 1'b0;
                        run_next = 1'b0;
                        acc      = 1'b1;
                    end
                end
                OP_OL_PRIMARY, OP_OL_SR, OP_OL_DUMMY:
                begin
                    acc = olm_reg;
                    if (olm_reg)
                    begin
                        olr_next[olr_bit] = item.enable_arg;
                    end
                end
                OP_PERIOD:
                begin
                    acc = olm_reg && (item.period_arg >= PERIOD_MIN_W)
                          && (item.period_arg <= PERIOD_MAX_W);
                    if (acc)
                    begin
                        period_next = item.period_arg;
                    end
                end
                OP_CNT_RESET:
                begin
                    acc = sel_ok;
                end
                default:
                begin
                    acc = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_SHUTDOWN;
            run_reg    <= 1'b0;
            olm_reg    <= 1'b0;
            olr_reg    <= 3'b000;
            drive_reg  <= 3'b000;
            period_reg <= PERIOD_MIN_W;
        end
        else
        begin
            mode_reg   <= mode_next;
            run_reg    <= run_next;
            olm_reg    <= olm_next;
            olr_reg    <= olr_next;
            drive_reg  <= drive_next;
            period_reg <= period_next;
        end
    end

    assign status.mode     = mode_next;
    assign status.drive    = drive_next;
    assign status.period   = period_next;
    assign status.accepted = acc;

    `DCDCFS_ASSERT_IMPL(a_shutdown_drive_off, mode_reg == MODE_SHUTDOWN, drive_reg == 3'b000, "drive on in shutdown")

endmodule

// ----- design/dcdc_fault_supervisor_top.sv -----
// dc-dc converter fault supervisor, top level: stream ports, input and result stages
// depends on dcdcfs_pkg, dcdcfs_cfg, dcdcfs_faults, dcdcfs_seq and the macro header
//
// usage:
//   s_* carries one command word per handshake: s_tuser holds the op code,
//   s_tdata the sample and argument fields. every accepted word yields exactly
//   one result word on m_*, in order, with the mode, drive bits, fault summary,
//   acceptance, period, filtered temperatures and the selected event counter.
//   cfg_* writes one threshold register per handshake (index 0..7); write only
//   while no command is in flight. cfg_ready is always high.
//   an accepted word moves from the input register to the result register when
//   the result stage is free; throughput is one word per cycle while m_tready
//   does not stall the output. all state updates for a word are made between
//   the input register and the result register. stall: while m_tready is low
//   the result is held, the input register takes one more word and s_tready
//   then drops until the result is taken. reset: all sequencer and fault state
//   clear, mode shutdown, period at its minimum, thresholds at their defaults.
`timescale 1ns / 1ps
`include "dcdc_fault_supervisor_top_defines.svh"

module dcdc_fault_supervisor_top (
    input  logic        clk,
    input  logic        rst_n,
    // op[3:0]
    input  logic [3:0]  s_tuser,
    // trip_flag[0], output_current_raw[12:1], output_voltage_raw[24:13],
    // pfc_fault_pin[25], interlock_pin[26], heatsink_1_sample[42:27],
    // heatsink_2_sample[58:43], enable_arg[59], period_arg[75:60],
    // counter_select[78:76], zero[79]
    input  logic [79:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // converter_mode[2:0], primary_pwm_on[3], sync_rect_on[4], dummy_load_on[5],
    // noncritical_active[6], critical_active[7], command_accepted[8],
    // primary_period[24:9], heatsink_1_temp[40:25], heatsink_2_temp[56:41],
    // event_count[72:57], zero[79:73]
    output logic [79:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import dcdcfs_pkg::*;

    item_t              item_in;
    item_t              item_reg;
    logic               in_valid_reg;
    logic               in_valid_next;
    result_t            res_reg;
    result_t            res_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_free;
    logic               fire;
    cfg_t               cfg;
    fault_sum_t         summary_next;
    logic signed [15:0] temp1_next;
    logic signed [15:0] temp2_next;
    logic [15:0]        count_sel;
    logic               sel_ok;
    seq_status_t        seq_status;

    assign item_in.op                 = s_tuser;
    assign item_in.trip_flag          = s_tdata[0];
    assign item_in.output_current_raw = s_tdata[12:1];
    assign item_in.output_voltage_raw = s_tdata[24:13];
    assign item_in.pfc_fault_pin      = s_tdata[25];
    assign item_in.interlock_pin      = s_tdata[26];
    assign item_in.heatsink_1_sample  = s_tdata[42:27];
    assign item_in.heatsink_2_sample  = s_tdata[58:43];
    assign item_in.enable_arg         = s_tdata[59];
    assign item_in.period_arg         = s_tdata[75:60];
    assign item_in.counter_select     = s_tdata[78:76];

    assign out_free  = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    dcdcfs_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    dcdcfs_faults u_faults (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .item         (item_reg),
        .cfg          (cfg),
        .summary_next (summary_next),
        .temp1_next   (temp1_next),
        .temp2_next   (temp2_next),
        .count_sel    (count_sel),
        .sel_ok       (sel_ok)
    );

    dcdcfs_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .cfg    (cfg),
        .faults (summary_next),
        .sel_ok (sel_ok),
        .status (seq_status)
    );

    always_comb
    begin
        res_next.converter_mode     = seq_status.mode;
        res_next.primary_pwm_on     = |(seq_status.drive & DRV_PRI);
        res_next.sync_rect_on       = |(seq_status.drive & DRV_SR);
        res_next.dummy_load_on      = |(seq_status.drive & DRV_DUMMY);
        res_next.noncritical_active = summary_next.noncritical;
        res_next.critical_active    = summary_next.critical;
        res_next.command_accepted   = seq_status.accepted;
        res_next.primary_period     = seq_status.period;
        res_next.heatsink_1_temp    = temp1_next;
        res_next.heatsink_2_temp    = temp2_next;
        res_next.event_count        = count_sel;
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= item_in;
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, res_reg.event_count, res_reg.heatsink_2_temp,
                       res_reg.heatsink_1_temp, res_reg.primary_period,
                       res_reg.command_accepted, res_reg.critical_active,
                       res_reg.noncritical_active, res_reg.dummy_load_on,
                       res_reg.sync_rect_on, res_reg.primary_pwm_on,
                       res_reg.converter_mode};

    `DCDCFS_ASSERT_NEXT(a_fire_gives_result, fire, out_valid_reg, "processed word left no result")

endmodule
